// ===== hdl/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // Fixed field geometry
    localparam int LETTER_W    = 5;
    localparam int MAX_LETTERS = 10;
    localparam int WORD_W      = LETTER_W * MAX_LETTERS;
    localparam int LEN_W       = 4;
    localparam int CODE_W      = 3;
    localparam int SLOT_W      = 5;
    localparam int ENTRY_W     = WORD_W + LEN_W;

    // Letter codes that map to a home slot (a .. z)
    localparam logic [LETTER_W-1:0] LETTER_LO = LETTER_W'(1);
    localparam logic [LETTER_W-1:0] LETTER_HI = LETTER_W'(26);

    // Request actions
    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_DEL = 2'd1;

    // Result codes
    localparam logic [CODE_W-1:0] CODE_ADDED    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_DUP      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_FULL     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_DELETED  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_NOTFOUND = 3'd4;
    localparam logic [CODE_W-1:0] CODE_LISTED   = 3'd5;
    localparam logic [CODE_W-1:0] CODE_EMPTY    = 3'd6;

    // Slot status
    typedef enum logic [1:0] {
        ST_NEVER = 2'd0,
        ST_TOMB  = 2'd1,
        ST_OCC   = 2'd2
    } slot_status_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_DEL,
        OP_DUMP
    } op_t;

    typedef struct packed {
        logic load;
        logic finish;
        op_t  op;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_done;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/lpht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl
    import lpht_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] action,
    input  wire dp_status_t sts,
    output logic            busy,
    output ctl_cmd_t        cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    op_t    req_op;

    always_comb
    begin
        case (action)
            ACT_ADD: req_op = OP_ADD;
            ACT_DEL: req_op = OP_DEL;
            default: req_op = OP_DUMP;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    op_next    = req_op;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_ADD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign cmd.load   = start && (state_reg == S_IDLE);
    assign cmd.finish = (state_reg == S_FINISH);
    assign cmd.op     = op_reg;

endmodule

`default_nettype wire

// ===== hdl/lpht_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp
    import lpht_pkg::*;
#(
    parameter int SLOTS = 26
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctl_cmd_t            cmd,
    output dp_status_t               sts,
    input  wire logic [WORD_W-1:0]   word,
    input  wire logic [LEN_W-1:0]    word_length,
    output logic                     result_valid,
    output logic [CODE_W-1:0]        code,
    output logic [SLOT_W-1:0]        slot,
    output logic [WORD_W-1:0]        entry_word,
    output logic [LEN_W-1:0]         entry_length,
    output logic                     last
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Word and length store, one read port and one write port
    logic [ENTRY_W-1:0] slot_mem [SLOTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;

    // Request key
    logic [WORD_W-1:0]  key_word_reg;
    logic [LEN_W-1:0]   key_len_reg;
    logic [IDX_W-1:0]   home_reg;

    logic [LEN_W-1:0]    norm_len;
    logic [WORD_W-1:0]   norm_word;
    logic [LETTER_W-1:0] last_code;
    logic [IDX_W-1:0]    norm_home;

    // Scan pipeline and search results
    logic               rd_run_reg, rd_run_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               found_vld_reg, found_vld_next;
    logic [IDX_W-1:0]   found_idx_reg, found_idx_next;
    logic               fge_vld_reg, fge_vld_next;
    logic [IDX_W-1:0]   fge_idx_reg, fge_idx_next;
    logic               fany_vld_reg, fany_vld_next;
    logic [IDX_W-1:0]   fany_idx_reg, fany_idx_next;

    slot_status_t       status_reg [SLOTS];
    slot_status_t       status_next [SLOTS];

    logic               res_vld_reg, res_vld_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [WORD_W-1:0]  ent_word_reg, ent_word_next;
    logic [LEN_W-1:0]   ent_len_reg, ent_len_next;
    logic               last_reg, last_next;

    logic               cmp_occ;
    logic               cmp_match;
    logic [SLOTS-1:0]   occ_vec;
    logic               later_occ;

    // Normalise the request: clamp length, clear unused letters, pick home slot
    always_comb
    begin
        if (word_length == '0)
        begin
            norm_len = LEN_W'(1);
        end
        else if (word_length > LEN_W'(MAX_LETTERS))
        begin
            norm_len = LEN_W'(MAX_LETTERS);
        end
        else
        begin
            norm_len = word_length;
        end
        norm_word = '0;
        last_code = '0;
        for (int k = 0; k < MAX_LETTERS; k++)
        begin
            if (LEN_W'(k) < norm_len)
            begin
                norm_word[k*LETTER_W +: LETTER_W] = word[k*LETTER_W +: LETTER_W];
            end
            if (LEN_W'(k + 1) == norm_len)
            begin
                last_code = word[k*LETTER_W +: LETTER_W];
            end
        end
        if (last_code inside {[LETTER_LO:LETTER_HI]})
        begin
            norm_home = IDX_W'(last_code - LETTER_LO);
        end
        else
        begin
            norm_home = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_word_reg <= norm_word;
            key_len_reg  <= norm_len;
            home_reg     <= norm_home;
        end
    end

    // Compare stage
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            occ_vec[j] = (status_reg[j] == ST_OCC);
        end
        later_occ = 1'b0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (occ_vec[j] && (IDX_W'(j) > cmp_idx_reg))
            begin
                later_occ = 1'b1;
            end
        end
        cmp_occ   = occ_vec[cmp_idx_reg];
        cmp_match = cmp_occ && (rd_data_reg == {key_len_reg, key_word_reg});
    end

    assign sts.scan_done = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);

    always_comb
    begin
        rd_run_next    = rd_run_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_vld_next   = rd_run_reg;
        cmp_idx_next   = rd_idx_reg;
        found_vld_next = found_vld_reg;
        found_idx_next = found_idx_reg;
        fge_vld_next   = fge_vld_reg;
        fge_idx_next   = fge_idx_reg;
        fany_vld_next  = fany_vld_reg;
        fany_idx_next  = fany_idx_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        res_vld_next   = 1'b0;
        code_next      = CODE_ADDED;
        slot_next      = '0;
        ent_word_next  = '0;
        ent_len_next   = '0;
        last_next      = 1'b0;

        // Advance the read address over every slot
        if (cmd.load)
        begin
            rd_run_next    = 1'b1;
            rd_idx_next    = '0;
            found_vld_next = 1'b0;
            fge_vld_next   = 1'b0;
            fany_vld_next  = 1'b0;
        end
        else if (rd_run_reg)
        begin
            if (rd_idx_reg == LAST_IDX)
            begin
                rd_run_next = 1'b0;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
        end

        // Track the first match, first free slot at or after home, first free slot
        if (cmp_vld_reg)
        begin
            if (cmp_match && !found_vld_reg)
            begin
                found_vld_next = 1'b1;
                found_idx_next = cmp_idx_reg;
            end
            if (!cmp_occ)
            begin
                if (!fany_vld_reg)
                begin
                    fany_vld_next = 1'b1;
                    fany_idx_next = cmp_idx_reg;
                end
                if (!fge_vld_reg && (cmp_idx_reg >= home_reg))
                begin
                    fge_vld_next = 1'b1;
                    fge_idx_next = cmp_idx_reg;
                end
            end
            if ((cmd.op == OP_DUMP) && cmp_occ)
            begin
                res_vld_next  = 1'b1;
                code_next     = CODE_LISTED;
                slot_next     = SLOT_W'(cmp_idx_reg);
                ent_word_next = rd_data_reg[WORD_W-1:0];
                ent_len_next  = rd_data_reg[ENTRY_W-1:WORD_W];
                last_next     = !later_occ;
            end
        end

        if (cmd.finish)
        begin
            case (cmd.op)
                OP_ADD:
                begin
                    res_vld_next = 1'b1;
                    last_next    = 1'b1;
                    if (found_vld_reg)
                    begin
                        code_next = CODE_DUP;
                    end
                    else if (fge_vld_reg || fany_vld_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = fge_vld_reg ? fge_idx_reg : fany_idx_reg;
                        status_next[mem_waddr] = ST_OCC;
                        code_next = CODE_ADDED;
                        slot_next = SLOT_W'(mem_waddr);
                    end
                    else
                    begin
                        code_next = CODE_FULL;
                    end
                end
                OP_DEL:
                begin
                    res_vld_next = 1'b1;
                    last_next    = 1'b1;
                    if (found_vld_reg)
                    begin
                        status_next[found_idx_reg] = ST_TOMB;
                        code_next = CODE_DELETED;
                        slot_next = SLOT_W'(found_idx_reg);
                    end
                    else
                    begin
                        code_next = CODE_NOTFOUND;
                    end
                end
                OP_DUMP:
                begin
                    if (occ_vec == '0)
                    begin
                        res_vld_next = 1'b1;
                        last_next    = 1'b1;
                        code_next    = CODE_EMPTY;
                    end
                end
                default:
                begin
                    res_vld_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= {key_len_reg, key_word_reg};
        end
        rd_data_reg <= slot_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_run_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            found_vld_reg <= 1'b0;
            found_idx_reg <= '0;
            fge_vld_reg   <= 1'b0;
            fge_idx_reg   <= '0;
            fany_vld_reg  <= 1'b0;
            fany_idx_reg  <= '0;
            for (int j = 0; j < SLOTS; j++)
            begin
                status_reg[j] <= ST_NEVER;
            end
            res_vld_reg   <= 1'b0;
            code_reg      <= CODE_ADDED;
            slot_reg      <= '0;
            ent_word_reg  <= '0;
            ent_len_reg   <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            rd_run_reg    <= rd_run_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            found_vld_reg <= found_vld_next;
            found_idx_reg <= found_idx_next;
            fge_vld_reg   <= fge_vld_next;
            fge_idx_reg   <= fge_idx_next;
            fany_vld_reg  <= fany_vld_next;
            fany_idx_reg  <= fany_idx_next;
            status_reg    <= status_next;
            res_vld_reg   <= res_vld_next;
            code_reg      <= code_next;
            slot_reg      <= slot_next;
            ent_word_reg  <= ent_word_next;
            ent_len_reg   <= ent_len_next;
            last_reg      <= last_next;
        end
    end

    assign result_valid = res_vld_reg;
    assign code         = code_reg;
    assign slot         = slot_reg;
    assign entry_word   = ent_word_reg;
    assign entry_length = ent_len_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ===== hdl/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Hash table of up to SLOTS lowercase words, home slot taken from the last letter,
// collisions resolved by linear probing with tombstones.
// Request channel: drive action, word and word_length with start high; the
// request is taken at a rising edge where start is high and busy is low.
// Actions: add (ignore a duplicate, report full and drop when no slot is free),
// delete (leave a tombstone), dump (list occupied slots in slot order).
// Result channel: each result sits on code, slot, entry_word, entry_length and
// last for exactly one cycle, marked by result_valid; last flags the final
// result of a request. The receiver has no way to stall, so nothing is held.
// Timing: every request scans all SLOTS entries through the word store, one
// registered read per cycle, and keeps busy high through the scan and the
// finish step. Add and delete give their single result in the first cycle
// that busy is low; dump results stream during the scan, the last one no later
// than that same cycle. The next request may be issued as soon as busy is low.
// Reset: every slot returns to never used; the word store itself is not cleared
// and needs no clearing pass, since only occupied slots are ever compared or listed.

module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int SLOTS = 26
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          action,
    input  wire logic [WORD_W-1:0]   word,
    input  wire logic [LEN_W-1:0]    word_length,
    output logic                     result_valid,
    output logic [CODE_W-1:0]        code,
    output logic [SLOT_W-1:0]        slot,
    output logic [WORD_W-1:0]        entry_word,
    output logic [LEN_W-1:0]         entry_length,
    output logic                     last
);

    ctl_cmd_t   cmd;
    dp_status_t sts;

    // Sequence each request: take it, hold busy through the scan, then finish
    lpht_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Scan the slots, track match and free slots, update status and emit results
    lpht_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .word         (word),
        .word_length  (word_length),
        .result_valid (result_valid),
        .code         (code),
        .slot         (slot),
        .entry_word   (entry_word),
        .entry_length (entry_length),
        .last         (last)
    );

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import lpht_pkg::*;

    localparam int TABLE_SLOTS = 26;
    localparam int CLK_PERIOD  = 4;
    // The block stays busy through each request's scan, and its final
    // result lands in the first cycle that busy is low.
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 8;
    localparam int DRAIN_LIMIT   = 4000;

    // Dump is action 2; action 3 behaves as a dump too.
    localparam logic [1:0] ACT_DUMP       = 2'd2;
    localparam logic [1:0] ACT_DUMP_ALIAS = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] entry_word;
        logic [LEN_W-1:0]  entry_length;
        logic              last;
    } table_reply_t;

    // One row of the directed plan. Rows with a pinned reply carry a result
    // that is obvious on sight; all others rely on the table mirror.
    typedef struct {
        logic [1:0]        act;
        logic [WORD_W-1:0] w;
        logic [LEN_W-1:0]  len;
        bit                pinned;
        logic [CODE_W-1:0] code;
        logic [SLOT_W-1:0] slot;
    } plan_row_t;

    // Block ports
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        action = ACT_ADD;
    logic [WORD_W-1:0] word = '0;
    logic [LEN_W-1:0]  word_length = LEN_W'(1);
    logic              result_valid;
    logic [CODE_W-1:0] code;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] entry_word;
    logic [LEN_W-1:0]  entry_length;
    logic              last;

    // Pinned reply travelling alongside the request on the command side
    bit                pin_reply = 1'b0;
    logic [CODE_W-1:0] pin_code = '0;
    logic [SLOT_W-1:0] pin_slot = '0;

    // Mirror of the table, updated as each request is taken
    slot_status_t      mirror_status [TABLE_SLOTS];
    logic [WORD_W-1:0] mirror_word   [TABLE_SLOTS];
    logic [LEN_W-1:0]  mirror_len    [TABLE_SLOTS];

    table_reply_t      awaited_replies [$];
    int                mismatch_count = 0;

    // Words sent with an add, reused to provoke duplicates and real deletes
    logic [WORD_W-1:0] known_words [$];
    logic [LEN_W-1:0]  known_lens  [$];

    // Directed plan
    plan_row_t         plan [$];

    linear_probe_hash_table #(
        .SLOTS(TABLE_SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .word        (word),
        .word_length (word_length),
        .result_valid(result_valid),
        .code        (code),
        .slot        (slot),
        .entry_word  (entry_word),
        .entry_length(entry_length),
        .last        (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            mirror_status[i] = ST_NEVER;
            mirror_word[i]   = '0;
            mirror_len[i]    = '0;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Append one reply to the tail of the awaited list.
    task automatic queue_reply(input table_reply_t r);
        awaited_replies.insert(awaited_replies.size(), r);
    endtask

    // Append one row to the directed plan.
    task automatic plan_step(input plan_row_t r);
        plan.insert(plan.size(), r);
    endtask

    function automatic table_reply_t make_reply(input logic [CODE_W-1:0] c,
                                                input int s,
                                                input logic [WORD_W-1:0] w,
                                                input logic [LEN_W-1:0] l,
                                                input logic lst);
        table_reply_t r;
        r.code         = c;
        r.slot         = SLOT_W'(s);
        r.entry_word   = w;
        r.entry_length = l;
        r.last         = lst;
        return r;
    endfunction

    // Pack a lowercase string, first letter in the lowest bits.
    function automatic logic [WORD_W-1:0] spell(input string s);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < s.len(); i++)
            w[i*LETTER_W +: LETTER_W] = LETTER_W'(s[i] - "a" + 1);
        return w;
    endfunction

    // Work out what one request does to the table and queue its replies.
    task automatic predict_table_op(input logic [1:0] act,
                                    input logic [WORD_W-1:0] raw_word,
                                    input logic [LEN_W-1:0] raw_len);
        int                n;
        int                home;
        int                hit;
        int                free_slot;
        int                s;
        int                listed;
        logic [WORD_W-1:0] w;
        logic [LETTER_W-1:0] tail;

        // Clamp the length, then ignore letters beyond it.
        n = raw_len;
        if (n < 1)
            n = 1;
        if (n > MAX_LETTERS)
            n = MAX_LETTERS;
        w    = raw_word & ({WORD_W{1'b1}} >> (WORD_W - n * LETTER_W));
        tail = w[(n - 1) * LETTER_W +: LETTER_W];
        // A last letter outside a..z homes on slot 0.
        home = (tail >= LETTER_LO && tail <= LETTER_HI) ? int'(tail) - 1 : 0;

        // Equality needs both letters and length to match.
        hit = -1;
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (hit < 0 && mirror_status[i] == ST_OCC && mirror_word[i] == w
                && int'(mirror_len[i]) == n)
                hit = i;

        if (act == ACT_ADD)
        begin
            if (hit >= 0)
                queue_reply(make_reply(CODE_DUP, 0, '0, '0, 1'b1));
            else
            begin
                // Probe forward from home, wrapping, taking a never-used or
                // tombstoned slot.
                free_slot = -1;
                for (int k = 0; k < TABLE_SLOTS; k++)
                begin
                    s = (home + k) % TABLE_SLOTS;
                    if (free_slot < 0 && mirror_status[s] != ST_OCC)
                        free_slot = s;
                end
                if (free_slot < 0)
                    queue_reply(make_reply(CODE_FULL, 0, '0, '0, 1'b1));
                else
                begin
                    mirror_status[free_slot] = ST_OCC;
                    mirror_word[free_slot]   = w;
                    mirror_len[free_slot]    = LEN_W'(n);
                    queue_reply(make_reply(CODE_ADDED, free_slot, '0, '0, 1'b1));
                end
            end
        end
        else if (act == ACT_DEL)
        begin
            if (hit < 0)
                queue_reply(make_reply(CODE_NOTFOUND, 0, '0, '0, 1'b1));
            else
            begin
                mirror_status[hit] = ST_TOMB;
                queue_reply(make_reply(CODE_DELETED, hit, '0, '0, 1'b1));
            end
        end
        else
        begin
            listed = 0;
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (mirror_status[i] == ST_OCC)
                begin
                    queue_reply(make_reply(CODE_LISTED, i, mirror_word[i],
                                           mirror_len[i], 1'b0));
                    listed++;
                end
            if (listed == 0)
                queue_reply(make_reply(CODE_EMPTY, 0, '0, '0, 1'b1));
            else
                awaited_replies[awaited_replies.size() - 1].last = 1'b1;
        end
    endtask

    // Watch both sides at every edge. All values read here are the ones that
    // held just before the edge, so the order of processes does not matter.
    // Check the outgoing result first: a dump's final result may share an
    // edge with the next request being taken.
    always @(posedge clk)
    begin
        table_reply_t due;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (awaited_replies.size() == 0)
                    flag_mismatch($sformatf("result with nothing awaited: code %0d slot %0d",
                                            code, slot));
                else
                begin
                    due = awaited_replies.pop_front();
                    if (code !== due.code)
                        flag_mismatch($sformatf("code %0d, expected %0d", code, due.code));
                    if (slot !== due.slot)
                        flag_mismatch($sformatf("slot %0d, expected %0d", slot, due.slot));
                    if (entry_word !== due.entry_word)
                        flag_mismatch($sformatf("entry_word %h, expected %h",
                                                entry_word, due.entry_word));
                    if (entry_length !== due.entry_length)
                        flag_mismatch($sformatf("entry_length %0d, expected %0d",
                                                entry_length, due.entry_length));
                    if (last !== due.last)
                        flag_mismatch($sformatf("last %0b, expected %0b", last, due.last));
                end
            end
            if (start && !busy)
            begin
                predict_table_op(action, word, word_length);
                // Swap the mirrored reply for the typed one on pinned rows.
                if (pin_reply)
                begin
                    void'(awaited_replies.pop_back());
                    queue_reply(make_reply(pin_code, pin_slot, '0, '0, 1'b1));
                end
            end
        end
    end

    // Present one request and hold it until the block takes it. Call at a
    // rising edge; return at the edge that took it, with start still high.
    task automatic send_request(input logic [1:0] act,
                                input logic [WORD_W-1:0] w,
                                input logic [LEN_W-1:0] l,
                                input bit pinned = 1'b0,
                                input logic [CODE_W-1:0] c = '0,
                                input logic [SLOT_W-1:0] s = '0);
        action      <= act;
        word        <= w;
        word_length <= l;
        pin_reply   <= pinned;
        pin_code    <= c;
        pin_slot    <= s;
        start       <= 1'b1;
        if (act == ACT_ADD)
        begin
            known_words.insert(known_words.size(), w);
            known_lens.insert(known_lens.size(), l);
        end
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start for a few random bursts, so that gaps land anywhere in the
    // block's scan; otherwise keep start high for the next request.
    task automatic sender_gap(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4))
                repeat ($urandom_range(1, 11))
                    @(posedge clk);
        end
    endtask

    // Hold off the sender until every awaited result has come back.
    task automatic wait_for_drain();
        int spent;
        spent = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            spent++;
        end
        while (awaited_replies.size() != 0 && spent < DRAIN_LIMIT);
    endtask

    task automatic random_word(output logic [WORD_W-1:0] w, output logic [LEN_W-1:0] l);
        logic [63:0]       noise;
        logic [WORD_W-1:0] keep;
        int                n;
        l = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(0, 15))
                                     : LEN_W'($urandom_range(1, MAX_LETTERS));
        n = (l == 0) ? 1 : ((l > MAX_LETTERS) ? MAX_LETTERS : int'(l));
        w = '0;
        for (int i = 0; i < n; i++)
            w[i*LETTER_W +: LETTER_W] = ($urandom_range(19) == 0)
                ? LETTER_W'($urandom_range(0, 31)) : LETTER_W'($urandom_range(1, 26));
        // Now and then fill the unused letter positions with junk.
        if ($urandom_range(4) == 0)
        begin
            noise = {$urandom, $urandom};
            keep  = {WORD_W{1'b1}} >> (WORD_W - n * LETTER_W);
            w     = w | (noise[WORD_W-1:0] & ~keep);
        end
    endtask

    // Directed plan, then a fill to overflow, then three random phases.
    initial
    begin
        plan_row_t         row;
        logic [WORD_W-1:0] w;
        logic [LEN_W-1:0]  l;
        logic [1:0]        act;
        int                pick;
        int                gap_pct;
        int                add_pct;
        int                del_pct;

        // Empty table, absent word, first add, duplicate, slot extremes.
        plan_step('{ACT_DUMP, '0, LEN_W'(1), 1'b1, CODE_EMPTY, SLOT_W'(0)});
        plan_step('{ACT_DEL, spell("a"), LEN_W'(1), 1'b1, CODE_NOTFOUND, SLOT_W'(0)});
        plan_step('{ACT_ADD, spell("a"), LEN_W'(1), 1'b1, CODE_ADDED, SLOT_W'(0)});
        plan_step('{ACT_ADD, spell("a"), LEN_W'(1), 1'b1, CODE_DUP, SLOT_W'(0)});
        plan_step('{ACT_ADD, spell("z"), LEN_W'(1), 1'b1, CODE_ADDED, SLOT_W'(25)});
        // Collision at slot 0, then a wrap from slot 25.
        plan_step('{ACT_ADD, spell("za"), LEN_W'(2), 1'b0, '0, '0});
        plan_step('{ACT_ADD, spell("az"), LEN_W'(2), 1'b0, '0, '0});
        // Over-long length clamps to ten letters; letter code 31 homes on 0.
        plan_step('{ACT_ADD, {WORD_W{1'b1}}, LEN_W'(15), 1'b0, '0, '0});
        plan_step('{ACT_ADD, {WORD_W{1'b1}}, LEN_W'(MAX_LETTERS), 1'b0, '0, '0});
        // Zero length taken as one; letter code 0 homes on 0.
        plan_step('{ACT_ADD, '0, LEN_W'(0), 1'b0, '0, '0});
        // Junk above the used letters is ignored: still a duplicate of "a".
        plan_step('{ACT_ADD, ~(WORD_W'(31)) | spell("a"), LEN_W'(1), 1'b0, '0, '0});
        // Same letters, different length: a different word.
        plan_step('{ACT_ADD, spell("a"), LEN_W'(2), 1'b0, '0, '0});
        plan_step('{ACT_DUMP, '0, '0, 1'b0, '0, '0});
        plan_step('{ACT_DEL, spell("a"), LEN_W'(1), 1'b1, CODE_DELETED, SLOT_W'(0)});
        // The search has to look past a tombstone; then reuse the tombstone.
        plan_step('{ACT_ADD, spell("za"), LEN_W'(2), 1'b0, '0, '0});
        plan_step('{ACT_ADD, spell("qa"), LEN_W'(2), 1'b0, '0, '0});
        plan_step('{ACT_DUMP_ALIAS, {WORD_W{1'b1}}, LEN_W'(15), 1'b0, '0, '0});
        plan_step('{ACT_DEL, {WORD_W{1'b1}}, LEN_W'(MAX_LETTERS), 1'b0, '0, '0});
        plan_step('{ACT_DEL, spell("za"), LEN_W'(2), 1'b0, '0, '0});
        plan_step('{ACT_DEL, spell("za"), LEN_W'(2), 1'b1, CODE_NOTFOUND, SLOT_W'(0)});
        plan_step('{ACT_ADD, spell("b"), LEN_W'(1), 1'b0, '0, '0});
        plan_step('{ACT_DUMP, '0, '0, 1'b0, '0, '0});

        // Hold reset low, then release it on an edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            send_request(row.act, row.w, row.len, row.pinned, row.code, row.slot);
            sender_gap(40);
        end

        // Pause until the directed part has fully answered.
        wait_for_drain();
        @(posedge clk);

        // Overflow the table: the last adds find no room. Then try a duplicate
        // and an absent delete on the full table, and list all 26 slots.
        repeat (TABLE_SLOTS + 4)
        begin
            random_word(w, l);
            send_request(ACT_ADD, w, l);
            sender_gap(20);
        end
        pick = $urandom_range(0, known_words.size() - 1);
        send_request(ACT_ADD, known_words[pick], known_lens[pick]);
        send_request(ACT_DEL, spell("qqqqqqqqqq"), LEN_W'(MAX_LETTERS));
        send_request(ACT_DUMP, '0, '0);

        // Random phases: delete-heavy, add-heavy, then mixed with no gaps.
        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 40 : ((phase == 1) ? 25 : 0);
            add_pct = (phase == 0) ? 25 : ((phase == 1) ? 70 : 45);
            del_pct = (phase == 0) ? 65 : ((phase == 1) ? 20 : 45);
            repeat (22)
            begin
                pick = $urandom_range(99);
                if (pick < add_pct)
                    act = ACT_ADD;
                else if (pick < add_pct + del_pct)
                    act = ACT_DEL;
                else
                    act = $urandom_range(1) ? ACT_DUMP : ACT_DUMP_ALIAS;
                random_word(w, l);
                // Reuse a known word most of the time on deletes and now and
                // then on adds, so that duplicates and real deletes occur.
                if (known_words.size() != 0
                    && ((act == ACT_DEL && $urandom_range(3) != 0)
                        || (act == ACT_ADD && $urandom_range(3) == 0)))
                begin
                    pick = $urandom_range(0, known_words.size() - 1);
                    w    = known_words[pick];
                    l    = known_lens[pick];
                end
                send_request(act, w, l);
                sender_gap(gap_pct);
            end
        end

        // Let the tail drain, then give the block time for any stray result.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (awaited_replies.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", awaited_replies.size()));

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #1000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== linear_probe_hash_table.f =====
hdl/lpht_pkg.sv
hdl/lpht_ctrl.sv
hdl/lpht_dp.sv
hdl/linear_probe_hash_table.sv
bench/tb_top.sv
